/* rtl/core/ecr_pkg.sv */
// ----------------------------------------------------------------------------
// ecr_pkg: shared types and constants for the empirical copula rank block
// Request payload structs and default sizes.
// ----------------------------------------------------------------------------
package ecr_pkg;

	localparam int MAX_ROWS_DEF    = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	localparam int IN_SAMPLE_W = 32;
	localparam int FRAC_BITS   = 16;            // Q1.16
	localparam int FRAC_W      = FRAC_BITS + 1;
	localparam int COUNT_W     = 7;

	typedef struct packed {
		logic [IN_SAMPLE_W-1:0] sample_value;
		logic                   last_sample;
	} ecr_in_t;

	typedef struct packed {
		logic [FRAC_W-1:0]  rank_fraction;
		logic [COUNT_W-1:0] less_equal_count;
		logic               truncated;
		logic               last_result;
	} ecr_out_t;

endpackage

/* rtl/core/empirical_copula_rank.sv */
// ----------------------------------------------------------------------------
// empirical_copula_rank: column rank transform with Q1.16 rank fraction
// Stores a column of samples, then emits per sample the count of stored
// samples <= it and that count over the row count, in load order.
// ----------------------------------------------------------------------------
//  channel | dir | payload    | request accepted when
//  --------+-----+------------+-------------------------
//  in      | in  | ecr_in_t   | in_valid  && in_ready
//  out     | out | ecr_out_t  | out_valid && out_ready
//
//  Loading accepts one sample per cycle; in_ready is high only while loading.
//  Each result takes a compare sweep over the stored rows through the single
//  store read port, then a pass through the bit-serial divider.
//  No clearing pass after reset; only written entries are ever read.
//  A stalled output holds the sequencer in its emit step.
module empirical_copula_rank
	import ecr_pkg::*;
#(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ecr_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output ecr_out_t out_data
);

	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int DCW = $clog2(FRAC_W);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_PIV   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]             state_q;
	logic [CW-1:0]          rows_q;
	logic                   ovf_q;
	logic [AW-1:0]          k_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          cnt_q;
	logic [SAMPLE_BITS-1:0] pivot_q;
	logic [CW:0]            div_r_q;
	logic [FRAC_W-1:0]      quo_q;
	logic [DCW-1:0]         div_cnt_q;
	logic                   out_valid_q;
	ecr_out_t               out_q;

	logic [SAMPLE_BITS-1:0] store_mem [MAX_ROWS];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [AW-1:0]          rd_addr;

	logic          in_acc;
	logic          room;
	logic          hit;
	logic [CW-1:0] cnt_next;
	logic [CW:0]   rows_ext;
	logic          div_ge;
	logic [CW:0]   div_diff;
	logic          out_free;
	logic          last_k;

	assign in_ready  = (state_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign room      = (rows_q < CW'(MAX_ROWS));
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// rd_q is the registered read of rd_addr; during the sweep it holds entry idx_q-1
	assign hit      = (rd_q <= pivot_q);
	assign cnt_next = cnt_q + CW'(hit);

	assign rows_ext = {1'b0, rows_q};
	assign div_ge   = (div_r_q >= rows_ext);
	assign div_diff = div_ge ? (div_r_q - rows_ext) : div_r_q;
	assign last_k   = ((CW'(k_q) + CW'(1)) == rows_q);

	always_comb begin
		unique case (state_q)
			S_FETCH: rd_addr = k_q;
			S_PIV:   rd_addr = '0;
			default: rd_addr = idx_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && room) begin
			store_mem[rows_q[AW-1:0]] <= SAMPLE_BITS'(in_data.sample_value);
		end
		rd_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			rows_q      <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (room) begin
							rows_q <= rows_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_data.last_sample) begin
							k_q     <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_PIV;
				end
				S_PIV: begin
					pivot_q <= rd_q;
					idx_q   <= CW'(1);
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					cnt_q <= cnt_next;
					if (idx_q == rows_q) begin
						div_r_q   <= {1'b0, cnt_next};
						div_cnt_q <= DCW'(FRAC_BITS);
						state_q   <= S_DIV;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DIV: begin
					// restoring division of count * 2^16 by rows, one bit per cycle
					quo_q   <= {quo_q[FRAC_W-2:0], div_ge};
					div_r_q <= {div_diff[CW-1:0], 1'b0};
					if (div_cnt_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						div_cnt_q <= div_cnt_q - DCW'(1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.rank_fraction    <= quo_q;
						out_q.less_equal_count <= COUNT_W'(cnt_q);
						out_q.truncated        <= ovf_q;
						out_q.last_result      <= last_k;
						if (last_k) begin
							rows_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_FETCH;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule
